// ----- design/command_line_keyword_parser_top_macros.svh -----
// Assertion macros used by the keyword parser top level.
`ifndef COMMAND_LINE_KEYWORD_PARSER_TOP_MACROS_SVH
`define COMMAND_LINE_KEYWORD_PARSER_TOP_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CLP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold at every clock edge outside reset.
`define CLP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- design/clp_pkg.sv -----
// Shared types, name table and constants of the command line keyword parser.
`default_nettype none

package clp_pkg;

  localparam int NameSlots = 17;
  localparam int PrefixLen = 8;
  localparam int QDepth    = 4;
  localparam int QAw       = $clog2(QDepth);

  typedef logic [NameSlots-1:0] clp_mask_t;

  // One classified text byte as it travels from the front end to the parser.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_zero;
    logic       is_lf;
    logic       is_blank;
    logic       is_gap;
    logic       is_dec;
    logic       is_x;
    logic       hex_ok;
    logic [3:0] nib;
  } clp_tok_t;

  typedef struct packed {
    logic        call_valid;
    logic [11:0] call_id;
    logic [63:0] call_arg;
    logic [7:0]  call_index;
    logic        text_done;
    logic [7:0]  calls_total;
  } clp_res_t;

  // Common lead-in shared by every command name, as ASCII codes.
  localparam logic [7:0] NAME_PREFIX [PrefixLen] = '{
    8'h48, 8'h41, 8'h43, 8'h5F, 8'h48, 8'h56, 8'h43, 8'h5F
  };

  // Name suffixes, right-justified; SFX_LEN gives the character count of each.
  localparam logic [127:0] NAME_SFX [NameSlots] = '{
    "VERSION", "DISPLAY_BLIT", "DISPLAY_BLANK", "DISPLAY_BRIGHT", "TOUCH_POLL",
    "WIFI_TX", "WIFI_RX", "WIFI_CONNECT", "STORAGE_READ", "STORAGE_WRITE",
    "GPIO_SET", "GPIO_GET", "SENSOR_READ", "CAMERA_CAPTURE", "AUDIO_PLAY",
    "POWER_SLEEP", "MODEM_AT"
  };

  localparam logic [4:0] SFX_LEN [NameSlots] = '{
    5'd7, 5'd12, 5'd13, 5'd14, 5'd10, 5'd7, 5'd7, 5'd12, 5'd12, 5'd13,
    5'd8, 5'd8, 5'd11, 5'd14, 5'd10, 5'd11, 5'd8
  };

  localparam logic [11:0] SLOT_ID [NameSlots] = '{
    12'h000, 12'h100, 12'h101, 12'h102, 12'h200, 12'h300, 12'h301, 12'h303,
    12'h400, 12'h401, 12'h500, 12'h501, 12'h600, 12'h700, 12'h800, 12'h900,
    12'hA00
  };

  // Character of a table name at a position; zero past the end of the name.
  function automatic logic [7:0] name_char(input int slot, input logic [4:0] pos);
    logic [4:0] k;
    logic [4:0] len;
    logic [4:0] idx;
    logic [7:0] ch;
    k   = pos - 5'(PrefixLen);
    len = SFX_LEN[slot];
    idx = len - k - 5'd1;
    if (pos < 5'(PrefixLen)) begin
      ch = NAME_PREFIX[pos[2:0]];
    end else if (k >= len) begin
      ch = 8'h00;
    end else begin
      ch = NAME_SFX[slot][{idx[3:0], 3'b000} +: 8];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- design/clp_front.sv -----
// Front end: accepts text bytes and classifies each character for the parser.
`default_nettype none

module clp_front (
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] text_byte
  input  wire logic              q_full,
  output logic                   q_push,
  output clp_pkg::clp_tok_t      q_tok
);
  import clp_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HX = 8'h66;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  logic is_alpha_hex;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  assign is_alpha_hex = (in_tdata >= CH_UA && in_tdata <= CH_UF) ||
                        (in_tdata >= CH_LA && in_tdata <= CH_LF_HX);

  always_comb begin
    q_tok.ch       = in_tdata;
    q_tok.is_zero  = (in_tdata == 8'h00);
    q_tok.is_lf    = (in_tdata == CH_LF);
    q_tok.is_gap   = (in_tdata == CH_SPACE) || (in_tdata == CH_TAB);
    q_tok.is_blank = q_tok.is_gap || (in_tdata == CH_LF) || (in_tdata == CH_CR);
    q_tok.is_dec   = (in_tdata >= CH_0) && (in_tdata <= CH_9);
    q_tok.is_x     = (in_tdata == CH_UX) || (in_tdata == CH_LX);
    q_tok.hex_ok   = q_tok.is_dec || is_alpha_hex;
    // Letters a-f and A-F have low nibbles 1 to 6, so adding nine gives 10 to 15.
    q_tok.nib      = is_alpha_hex ? (in_tdata[3:0] + 4'd9) : in_tdata[3:0];
  end

endmodule

`default_nettype wire

// ----- design/clp_queue.sv -----
// Short queue of classified characters between the front end and the parser.
`default_nettype none

module clp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire clp_pkg::clp_tok_t push_tok,
  output logic                   full,
  input  wire logic              pop,
  output logic                   pop_valid,
  output clp_pkg::clp_tok_t      pop_tok
);
  import clp_pkg::*;

  clp_tok_t         slots_r [QDepth];
  logic [QAw-1:0]   wr_ptr_r;
  logic [QAw-1:0]   rd_ptr_r;
  logic [QAw:0]     level_r;

  assign full      = (level_r == (QAw+1)'(QDepth));
  assign pop_valid = (level_r != '0);
  assign pop_tok   = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/clp_back.sv -----
// Back end: line parser with name matching, argument reading and result register.
`default_nettype none

module clp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        call_limit,
  input  wire logic              q_valid,
  input  wire clp_pkg::clp_tok_t q_tok,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output clp_pkg::clp_res_t      out_res
);
  import clp_pkg::*;

  localparam logic [2:0] PH_LINE   = 3'd0;
  localparam logic [2:0] PH_NAME   = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_GAP    = 3'd3;
  localparam logic [2:0] PH_ZERO   = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;
  localparam logic [2:0] PH_TAIL   = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  clp_mask_t   mask_r, mask_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [11:0] id_r, id_nxt;
  logic [63:0] arg_r, arg_nxt;
  logic        hex_r, hex_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        out_valid_r;
  clp_res_t    out_res_r;
  clp_res_t    res_nxt;

  logic        pending;
  logic        emit;
  logic        slot_free;
  logic        fire;
  logic [4:0]  m_pos;
  clp_mask_t   m_base;
  clp_mask_t   m_hit;
  clp_mask_t   m_done;
  logic [11:0] m_id;
  logic        m_complete;
  logic        m_empty;
  logic [63:0] arg_dec;
  logic [63:0] arg_hex;

  assign pending   = (phase_r inside {PH_GAP, PH_ZERO, PH_DIGITS, PH_TAIL});
  assign emit      = q_tok.is_zero || (pending && q_tok.is_lf);
  assign slot_free = !out_valid_r || out_ready;
  assign fire      = q_valid && (!emit || slot_free);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // A new line starts matching at position zero with every name still a candidate.
  assign m_pos  = (phase_r == PH_NAME) ? pos_r : 5'd0;
  assign m_base = (phase_r == PH_NAME) ? mask_r : '1;

  always_comb begin
    for (int i = 0; i < NameSlots; i++) begin
      m_hit[i]  = m_base[i] && (name_char(i, m_pos) == q_tok.ch);
      m_done[i] = m_hit[i] && (name_char(i, m_pos + 5'd1) == 8'h00);
    end
  end

  always_comb begin
    m_id = '0;
    for (int i = NameSlots - 1; i >= 0; i--) begin
      if (m_done[i]) begin
        m_id = SLOT_ID[i];
      end
    end
  end

  assign m_complete = |m_done;
  assign m_empty    = ~|m_hit;

  assign arg_dec = (arg_r << 3) + (arg_r << 1) + {60'd0, q_tok.nib};
  assign arg_hex = {arg_r[59:0], q_tok.nib};

  always_comb begin
    res_nxt.call_valid  = pending;
    res_nxt.call_id     = pending ? id_r : 12'd0;
    res_nxt.call_arg    = pending ? arg_r : 64'd0;
    res_nxt.call_index  = pending ? count_r : 8'd0;
    res_nxt.text_done   = q_tok.is_zero;
    res_nxt.calls_total = q_tok.is_zero ? (count_r + {7'd0, pending}) : 8'd0;
  end

  always_comb begin
    phase_nxt = phase_r;
    mask_nxt  = mask_r;
    pos_nxt   = pos_r;
    id_nxt    = id_r;
    arg_nxt   = arg_r;
    hex_nxt   = hex_r;
    count_nxt = count_r;
    if (fire) begin
      if (q_tok.is_zero) begin
        phase_nxt = PH_LINE;
        mask_nxt  = '1;
        pos_nxt   = '0;
        id_nxt    = '0;
        arg_nxt   = '0;
        hex_nxt   = 1'b0;
        count_nxt = '0;
      end else if (emit) begin
        phase_nxt = PH_LINE;
        count_nxt = count_r + 8'd1;
      end else begin
        case (phase_r)
          PH_NAME: begin
            mask_nxt = m_hit;
            pos_nxt  = pos_r + 5'd1;
            if (m_complete) begin
              id_nxt    = m_id;
              arg_nxt   = '0;
              hex_nxt   = 1'b0;
              phase_nxt = PH_GAP;
            end else if (m_empty) begin
              phase_nxt = q_tok.is_lf ? PH_LINE : PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (q_tok.is_lf) begin
              phase_nxt = PH_LINE;
            end
          end
          PH_GAP: begin
            if (q_tok.is_gap) begin
              phase_nxt = PH_GAP;
            end else if (q_tok.is_dec && q_tok.nib == 4'd0) begin
              phase_nxt = PH_ZERO;
            end else if (q_tok.is_dec) begin
              arg_nxt   = {60'd0, q_tok.nib};
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_TAIL;
            end
          end
          PH_ZERO: begin
            if (q_tok.is_x) begin
              hex_nxt   = 1'b1;
              arg_nxt   = '0;
              phase_nxt = PH_DIGITS;
            end else if (q_tok.is_dec) begin
              arg_nxt   = {60'd0, q_tok.nib};
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_TAIL;
            end
          end
          PH_DIGITS: begin
            if (hex_r && q_tok.hex_ok) begin
              arg_nxt = arg_hex;
            end else if (!hex_r && q_tok.is_dec) begin
              arg_nxt = arg_dec;
            end else begin
              phase_nxt = PH_TAIL;
            end
          end
          PH_TAIL: begin
            phase_nxt = PH_TAIL;
          end
          default: begin
            // Line start; an unused phase code falls back here as well.
            phase_nxt = PH_LINE;
            if (!q_tok.is_blank && (count_r < call_limit)) begin
              mask_nxt = m_hit;
              pos_nxt  = 5'd1;
              if (m_complete) begin
                id_nxt    = m_id;
                arg_nxt   = '0;
                hex_nxt   = 1'b0;
                phase_nxt = PH_GAP;
              end else if (m_empty) begin
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = PH_NAME;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LINE;
      mask_r      <= '1;
      pos_r       <= '0;
      id_r        <= '0;
      arg_r       <= '0;
      hex_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      mask_r  <= mask_nxt;
      pos_r   <= pos_nxt;
      id_r    <= id_nxt;
      arg_r   <= arg_nxt;
      hex_r   <= hex_nxt;
      count_r <= count_nxt;
      if (fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/command_line_keyword_parser_top.sv -----
// Top level of the command line keyword parser: ports, register file and assertions.
//
//   Channel   Direction  Signals                          Content
//   in_       slave      in_tvalid/in_tready/in_tdata     one text byte per transfer
//   out_      master     out_tvalid/out_tready/out_tdata  one command or done record
//                        out_tuser
//   cfg_      APB slave  psel/penable/pwrite/paddr/...    call_limit at address 0
//
// The block takes one text byte per cycle while in_tready is high. A classified byte
// waits in a four-entry queue; the parser retires one byte per cycle unless an ending
// byte is held back, and it registers the result of a line in the output register.
// A byte that ends a command line or the text waits in the queue while the single
// output register still holds an untaken result; once four bytes wait, in_tready drops.
// Reset is synchronous and active low; call_limit returns to 16.
`default_nettype none

`include "command_line_keyword_parser_top_macros.svh"

module command_line_keyword_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] text_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,   // [11:0] call_id, [75:12] call_arg,
                                        // [83:76] call_index, [91:84] calls_total,
                                        // [95:92] zero
  output logic [1:0]       out_tuser,   // [0] call_valid, [1] text_done
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import clp_pkg::*;

  localparam logic REG_CALL_LIMIT = 1'b0;

  logic        [7:0] call_limit_r;
  logic        cfg_wr;
  logic        q_full;
  logic        q_push;
  clp_tok_t    q_in_tok;
  logic        q_pop;
  logic        q_valid;
  clp_tok_t    q_out_tok;
  clp_res_t    res;
  logic        out_cmd;
  logic        out_done;
  logic        out_bare;
  logic [83:0] cmd_fields;
  logic [7:0]  out_total;
  logic [7:0]  out_next;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_CALL_LIMIT) ? {24'd0, call_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      call_limit_r <= 8'd16;
    end else if (cfg_wr && (cfg_paddr[2] == REG_CALL_LIMIT)) begin
      call_limit_r <= cfg_pwdata[7:0];
    end
  end

  clp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_tok     (q_in_tok)
  );

  clp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (q_in_tok),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_tok   (q_out_tok)
  );

  clp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .call_limit (call_limit_r),
    .q_valid    (q_valid),
    .q_tok      (q_out_tok),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {4'd0, res.calls_total, res.call_index, res.call_arg, res.call_id};
  assign out_tuser = {res.text_done, res.call_valid};

  assign out_cmd    = out_tvalid && out_tuser[0];
  assign out_done   = out_tvalid && out_tuser[1];
  assign out_bare   = out_tvalid && !out_tuser[0];
  assign cmd_fields = out_tdata[83:0];
  assign out_total  = out_tdata[91:84];
  assign out_next   = out_tdata[83:76] + 8'd1;

  // Every result is a command record, a done record, or both.
  `CLP_ASSERT_ALWAYS(a_result_kind, !out_tvalid || out_cmd || out_done, "empty result record")
  // A done record that also carries a command counts that command in its total.
  `CLP_ASSERT_IMPLIES(a_done_total, out_cmd && out_done, out_total == out_next, "bad done total")
  // Without a command, the command fields are all zero.
  `CLP_ASSERT_IMPLIES(a_idle_fields, out_bare, cmd_fields == 84'd0, "stray command fields")
  // Backpressure at the input only comes from a queue that holds characters.
  `CLP_ASSERT_IMPLIES(a_stall_cause, !in_tready, q_valid, "input stalled with an empty queue")

endmodule

`default_nettype wire

// ----- dv/command_line_keyword_parser_top_test.sv -----
// Self-checking testbench for the command line keyword parser top level.
`timescale 1ns / 1ps

module command_line_keyword_parser_top_test;
  import clp_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  typedef enum logic [2:0] {
    AT_LINE, IN_NAME, SKIP_LINE, ARG_GAP, ARG_ZERO, ARG_DIGITS, ARG_TAIL
  } parse_state_e;

  localparam logic [2:0] CALL_LIMIT_ADDR = 3'd0;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam int HOLD_CYCLES = 300;

  // Tracks the parse of the text stream and holds the command records still owed.
  class command_tracker;
    localparam logic [63:0] NAME_LEAD = 64'h4841_435F_4856_435F;

    clp_res_t     due_records [$];
    int           errors;
    int           results_seen;
    logic [7:0]   call_limit;
    parse_state_e state;
    logic [16:0]  cands;
    logic [4:0]   name_pos;
    logic [11:0]  cmd_id;
    logic [63:0]  arg;
    bit           hex_arg;
    logic [7:0]   count;

    function new();
      call_limit = 8'd16;
      clear_text();
    endfunction

    static function string cmd_suffix(int slot);
      case (slot)
        0:  return "VERSION";
        1:  return "DISPLAY_BLIT";
        2:  return "DISPLAY_BLANK";
        3:  return "DISPLAY_BRIGHT";
        4:  return "TOUCH_POLL";
        5:  return "WIFI_TX";
        6:  return "WIFI_RX";
        7:  return "WIFI_CONNECT";
        8:  return "STORAGE_READ";
        9:  return "STORAGE_WRITE";
        10: return "GPIO_SET";
        11: return "GPIO_GET";
        12: return "SENSOR_READ";
        13: return "CAMERA_CAPTURE";
        14: return "AUDIO_PLAY";
        15: return "POWER_SLEEP";
        16: return "MODEM_AT";
        default: return "";
      endcase
    endfunction

    static function logic [11:0] cmd_code(int slot);
      case (slot)
        0:  return 12'h000;
        1:  return 12'h100;
        2:  return 12'h101;
        3:  return 12'h102;
        4:  return 12'h200;
        5:  return 12'h300;
        6:  return 12'h301;
        7:  return 12'h303;
        8:  return 12'h400;
        9:  return 12'h401;
        10: return 12'h500;
        11: return 12'h501;
        12: return 12'h600;
        13: return 12'h700;
        14: return 12'h800;
        15: return 12'h900;
        default: return 12'hA00;
      endcase
    endfunction

    // Character of a command name at a position, zero past its end.
    static function logic [7:0] cmd_char(int slot, int pos);
      string s;
      s = cmd_suffix(slot);
      if (pos < 8) return NAME_LEAD[63-8*pos -: 8];
      if (pos - 8 >= s.len()) return CH_NUL;
      return s[pos-8];
    endfunction

    static function int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - 8'h30);
      if (c >= "a" && c <= "f") return int'(c - 8'h61) + 10;
      if (c >= "A" && c <= "F") return int'(c - 8'h41) + 10;
      return -1;
    endfunction

    function void clear_text();
      state    = AT_LINE;
      cands    = '1;
      name_pos = '0;
      cmd_id   = '0;
      arg      = '0;
      hex_arg  = 1'b0;
      count    = '0;
    endfunction

    function void set_limit(logic [7:0] v);
      call_limit = v;
    endfunction

    function int pending();
      return due_records.size();
    endfunction

    // Narrows the candidate set by one byte: 1 on a complete name, -1 when none is left.
    function int narrow(logic [7:0] c);
      logic [16:0] nxt;
      nxt = '0;
      for (int i = 0; i < 17; i++) begin
        if (cands[i] && cmd_char(i, name_pos) == c) nxt[i] = 1'b1;
      end
      cands    = nxt;
      name_pos = name_pos + 5'd1;
      if (nxt == '0) return -1;
      for (int i = 0; i < 17; i++) begin
        if (nxt[i] && cmd_char(i, name_pos) == CH_NUL) begin
          cmd_id = cmd_code(i);
          return 1;
        end
      end
      return 0;
    endfunction

    function void follow_match(int hit, parse_state_e on_miss);
      if (hit > 0) begin
        arg     = '0;
        hex_arg = 1'b0;
        state   = ARG_GAP;
      end else if (hit < 0) begin
        state = on_miss;
      end else begin
        state = IN_NAME;
      end
    endfunction

    function void note_byte(logic [7:0] c);
      clp_res_t rec;
      bit       open_cmd;
      int       d;
      open_cmd = (state >= ARG_GAP && state <= ARG_TAIL);
      if (c == CH_NUL || (open_cmd && c == CH_LF)) begin
        rec = '0;
        if (open_cmd) begin
          rec.call_valid = 1'b1;
          rec.call_id    = cmd_id;
          rec.call_arg   = arg;
          rec.call_index = count;
          count          = count + 8'd1;
        end
        if (c == CH_NUL) begin
          rec.text_done   = 1'b1;
          rec.calls_total = count;
          clear_text();
        end else begin
          state = AT_LINE;
        end
        due_records.push_back(rec);
        return;
      end
      case (state)
        IN_NAME: begin
          follow_match(narrow(c), (c == CH_LF) ? AT_LINE : SKIP_LINE);
        end
        SKIP_LINE: begin
          if (c == CH_LF) state = AT_LINE;
        end
        ARG_GAP: begin
          if (c == CH_SP || c == CH_TAB) begin
            state = ARG_GAP;
          end else if (c == "0") begin
            state = ARG_ZERO;
          end else if (c >= "1" && c <= "9") begin
            arg   = 64'(c - 8'h30);
            state = ARG_DIGITS;
          end else begin
            state = ARG_TAIL;
          end
        end
        ARG_ZERO: begin
          if (c == "x" || c == "X") begin
            hex_arg = 1'b1;
            arg     = '0;
            state   = ARG_DIGITS;
          end else if (c >= "0" && c <= "9") begin
            arg   = 64'(c - 8'h30);
            state = ARG_DIGITS;
          end else begin
            state = ARG_TAIL;
          end
        end
        ARG_DIGITS: begin
          if (hex_arg) begin
            d = hex_digit(c);
            if (d >= 0) arg = {arg[59:0], 4'(d)};
            else state = ARG_TAIL;
          end else if (c >= "0" && c <= "9") begin
            arg = arg * 64'd10 + 64'(c - 8'h30);
          end else begin
            state = ARG_TAIL;
          end
        end
        ARG_TAIL: begin
        end
        default: begin
          state = AT_LINE;
          // Blank bytes and lines past the limit leave the parser at line start.
          if (!(c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR) &&
              count < call_limit) begin
            cands    = '1;
            name_pos = '0;
            follow_match(narrow(c), SKIP_LINE);
          end
        end
      endcase
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_record(logic [95:0] data, logic [1:0] user);
      clp_res_t want;
      results_seen++;
      if (due_records.size() == 0) begin
        $error("record with nothing outstanding: tdata %0h tuser %0h", data, user);
        errors++;
        return;
      end
      want = due_records.pop_front();
      compare("call_valid",  64'(want.call_valid),  64'(user[0]));
      compare("call_id",     64'(want.call_id),     64'(data[11:0]));
      compare("call_arg",    want.call_arg,         data[75:12]);
      compare("call_index",  64'(want.call_index),  64'(data[83:76]));
      compare("text_done",   64'(want.text_done),   64'(user[1]));
      compare("calls_total", 64'(want.calls_total), 64'(data[91:84]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int bytes_sent = 0;

  command_tracker sb = new;

  command_line_keyword_parser_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void add_str(ref byte_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // Pushes the first n characters of a command name, or all of it for n < 0.
  function automatic void add_name(ref byte_q_t q, input int slot, input int n = -1);
    for (int p = 0; command_tracker::cmd_char(slot, p) != CH_NUL; p++) begin
      if (n >= 0 && p >= n) break;
      q.push_back(command_tracker::cmd_char(slot, p));
    end
  endfunction

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] any_printable();
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic void add_random_line(ref byte_q_t q);
    string hex_chars = "0123456789abcdefABCDEF";
    int    kind = $urandom_range(0, 99);
    int    slot = $urandom_range(0, 16);
    int    n;
    n = $urandom_range(0, 2);
    repeat (n) q.push_back(any_blank());
    if (kind < 72) begin
      add_name(q, slot);
      n = $urandom_range(0, 3);
      repeat (n) q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
      case ($urandom_range(0, 5))
        0: begin
        end
        1: begin
          q.push_back(8'($urandom_range(8'h31, 8'h39)));
          n = $urandom_range(0, 21);
          repeat (n) q.push_back(8'($urandom_range(8'h30, 8'h39)));
        end
        2, 3: begin
          q.push_back("0");
          q.push_back($urandom_range(0, 1) ? 8'h78 : 8'h58);
          n = $urandom_range(0, 18);
          repeat (n) q.push_back(hex_chars[$urandom_range(0, 21)]);
        end
        4: begin
          q.push_back("0");
          n = $urandom_range(0, 4);
          repeat (n) q.push_back(8'($urandom_range(8'h30, 8'h39)));
        end
        default: q.push_back(any_printable());
      endcase
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) q.push_back(any_printable());
      end
    end else if (kind < 86) begin
      // A name cut short, then the line end, sometimes after one to four stray characters.
      add_name(q, slot, $urandom_range(1, 8 + command_tracker::cmd_suffix(slot).len() - 1));
      if ($urandom_range(0, 1)) begin
        n = $urandom_range(1, 4);
        repeat (n) q.push_back(any_printable());
      end
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) q.push_back(8'($urandom_range(1, 255)));
    end
    q.push_back(CH_LF);
  endfunction

  function automatic void add_random_text(ref byte_q_t q, input int lines);
    for (int i = 0; i < lines; i++) add_random_line(q);
    // Sometimes the end-of-text byte closes the last command line itself.
    if ($urandom_range(0, 2) == 0) void'(q.pop_back());
    q.push_back(CH_NUL);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // Stops offering bytes and waits until every owed record has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == CALL_LIMIT_ADDR) sb.set_limit(data[7:0]);
  endtask

  task automatic set_call_limit(input logic [7:0] v);
    drain();
    // Let any trailing bytes that owe nothing clear the parser queue.
    repeat (8) @(posedge clk);
    cfg_write(CALL_LIMIT_ADDR, {24'h0, v});
  endtask

  task automatic run_directed();
    byte_q_t q;
    q = {};
    q.push_back(CH_NUL);
    send_text(q);

    q = {};
    add_str(q, " \t\r\n");
    add_name(q, 0);  add_str(q, "\n");
    add_name(q, 1);  add_str(q, " 18446744073709551615\n");
    add_name(q, 2);  add_str(q, "\t99999999999999999999\n");
    add_name(q, 3);  add_str(q, " 0xFFFFFFFFFFFFFFFF\n");
    add_name(q, 4);  add_str(q, " 0XaBcD\n");
    add_name(q, 5);  add_str(q, " 0x\n");
    add_name(q, 6);  add_str(q, " zz 12\n");
    add_name(q, 7);  add_str(q, "0\n");
    add_name(q, 8);  add_str(q, " 007\n");
    add_name(q, 9, 11);  add_str(q, "\n");
    add_name(q, 10, 9);  add_str(q, "Q junk 5\n");
    add_str(q, "\r junk line\n");
    add_name(q, 9);  add_str(q, "\t \t123abc\n");
    add_name(q, 10); add_str(q, " 0x1g2\n");
    add_name(q, 11); add_str(q, "  00x5\n");
    add_name(q, 12); add_str(q, " 42 7\n");
    add_name(q, 13); add_str(q, " 0xdeadbeefcafef00d1\n");
    add_name(q, 14); add_str(q, "\n");
    add_name(q, 15); add_str(q, " 5\n");
    // The seventeenth command of the text lies past the default limit.
    add_name(q, 16); add_str(q, " 9\n");
    q.push_back(CH_NUL);
    send_text(q);

    q = {};
    add_str(q, "  ");
    add_name(q, 16); add_str(q, " 0x1f");
    q.push_back(CH_NUL);
    send_text(q);
  endtask

  initial begin : stimulus
    byte_q_t q;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        1: set_call_limit(8'd0);
        2: set_call_limit(8'd255);
        3: set_call_limit(8'd1);
        4: set_call_limit(8'd3);
        5: set_call_limit(8'($urandom_range(0, 255)));
        6: set_call_limit(8'd16);
        default: begin
        end
      endcase
      if (ph == 2) begin
        // Receiver stalls for a long stretch while short command lines keep coming.
        hold_req = 1'b1;
        idle_on  = 1'b0;
        q = {};
        repeat (5) begin
          add_name(q, $urandom_range(0, 16));
          q.push_back(CH_LF);
        end
        q.push_back(CH_NUL);
        send_text(q);
      end
      for (int t = 0; t < 1 || (ph == 6 && (bytes_sent < 1100 || sb.results_seen < 60));
           t++) begin
        idle_on = ($urandom_range(0, 3) != 0);
        q = {};
        add_random_text(q, $urandom_range(1, 4));
        send_text(q);
        if (ph == 3 && t == 0) drain();
      end
    end
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : record_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_record(out_tdata, out_tuser);
    end
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/clp_pkg.sv
design/clp_front.sv
design/clp_queue.sv
design/clp_back.sv
design/command_line_keyword_parser_top.sv
dv/command_line_keyword_parser_top_test.sv
